>>> hdl/sprite_line_engine_top_macros.svh
// Assertion macros for the sprite line engine checker
`ifndef SPRITE_LINE_ENGINE_TOP_MACROS_SVH
`define SPRITE_LINE_ENGINE_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define SLE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/sle_pkg.sv
// Shared types and constants of the sprite line engine
package sle_pkg;
  localparam int MemBytes = 16384;
  localparam int MemAw = $clog2(MemBytes);
  localparam int LatchCount = 4;
  localparam int LatchIw = 2;
  localparam int AttrEntries = 32;

  typedef enum logic [2:0] {
    ACT_WR_MEM = 3'd0, ACT_WR_PIX = 3'd1, ACT_RD_PIX = 3'd2,
    ACT_WR_STAT = 3'd3, ACT_EVAL = 3'd4, ACT_COMP = 3'd5,
    ACT_NONE6 = 3'd6, ACT_NONE7 = 3'd7
  } action_t;

  localparam logic [1:0] REG_ATTR_BASE = 2'd0;
  localparam logic [1:0] REG_PAT_BASE  = 2'd1;
  localparam logic [1:0] REG_SIZE_MODE = 2'd2;

  // datapath operation selected by the controller each cycle
  typedef enum logic [3:0] {
    OP_IDLE, OP_SIMPLE, OP_EV_INIT, OP_EV_Y, OP_EV_CHECK, OP_EV_X, OP_EV_NAME,
    OP_EV_ATTR, OP_EV_PAT0, OP_EV_PAT1, OP_EV_DONE, OP_CP_INIT, OP_CP_READ,
    OP_CP_WRITE, OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ev_stop;   // scan ends after this entry
    logic ev_hit;    // entry covers the line
    logic ev_last;   // entry index has passed the last table entry
    logic ev_end;    // entry being checked is the last of the table
    logic cp_done;   // all sprite pixels visited
  } stat_t;
endpackage

>>> hdl/sle_ctrl.sv
// Controller sequencing actions through the datapath
module sle_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [2:0] action,
  input  sle_pkg::stat_t stat,
  output sle_pkg::cmd_t cmd,
  output logic busy
);
  import sle_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_SIMPLE, S_EV_INIT, S_EV_Y, S_EV_CHECK, S_EV_X, S_EV_NAME, S_EV_ATTR,
    S_EV_PAT0, S_EV_PAT1, S_EV_DONE, S_CP_INIT, S_CP_READ, S_CP_WRITE, S_DONE
  } state_t;
  state_t state;

  // command decode from state
  always_comb begin
    unique case (state)
      S_IDLE:     cmd.op = OP_IDLE;
      S_SIMPLE:   cmd.op = OP_SIMPLE;
      S_EV_INIT:  cmd.op = OP_EV_INIT;
      S_EV_Y:     cmd.op = OP_EV_Y;
      S_EV_CHECK: cmd.op = OP_EV_CHECK;
      S_EV_X:     cmd.op = OP_EV_X;
      S_EV_NAME:  cmd.op = OP_EV_NAME;
      S_EV_ATTR:  cmd.op = OP_EV_ATTR;
      S_EV_PAT0:  cmd.op = OP_EV_PAT0;
      S_EV_PAT1:  cmd.op = OP_EV_PAT1;
      S_EV_DONE:  cmd.op = OP_EV_DONE;
      S_CP_INIT:  cmd.op = OP_CP_INIT;
      S_CP_READ:  cmd.op = OP_CP_READ;
      S_CP_WRITE: cmd.op = OP_CP_WRITE;
      default:    cmd.op = OP_DONE;
    endcase
  end

  // state register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            if (action == ACT_EVAL) state <= S_EV_INIT;
            else if (action == ACT_COMP) state <= S_CP_INIT;
            else state <= S_SIMPLE;
          end
        end
        S_SIMPLE:   state <= S_DONE;
        S_EV_INIT:  state <= S_EV_Y;
        S_EV_Y:     state <= S_EV_CHECK;
        S_EV_CHECK: begin
          if (stat.ev_stop) state <= S_EV_DONE;
          else if (stat.ev_hit) state <= S_EV_X;
          else if (stat.ev_end) state <= S_EV_DONE;
          else state <= S_EV_Y;
        end
        S_EV_X:     state <= S_EV_NAME;
        S_EV_NAME:  state <= S_EV_ATTR;
        S_EV_ATTR:  state <= S_EV_PAT0;
        S_EV_PAT0:  state <= S_EV_PAT1;
        S_EV_PAT1:  state <= stat.ev_last ? S_EV_DONE : S_EV_Y;
        S_EV_DONE:  state <= S_DONE;
        S_CP_INIT:  state <= stat.cp_done ? S_DONE : S_CP_READ;
        S_CP_READ:  state <= S_CP_WRITE;
        S_CP_WRITE: state <= stat.cp_done ? S_DONE : S_CP_READ;
        S_DONE: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/sle_datapath.sv
// Datapath: memories, sprite latches, status and result registers
module sle_datapath (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  sle_pkg::cmd_t cmd,
  output sle_pkg::stat_t stat,
  input  logic [2:0] action,
  input  logic [13:0] mem_address,
  input  logic [7:0] data_byte,
  input  logic [7:0] pixel_x,
  input  logic [7:0] scan_line,
  input  logic [13:0] attribute_base,
  input  logic [13:0] pattern_base,
  input  logic [1:0] size_mode,
  output logic [7:0] read_pixel,
  output logic [7:0] status_byte,
  output logic [15:0] collision_place,
  output logic [2:0] sprites_latched,
  output logic done
);
  import sle_pkg::*;

  // captured item
  logic [2:0] act_q;
  logic [13:0] addr_q;
  logic [7:0] data_q, px_q, line_q;

  logic [7:0] vmem [MemBytes];
  logic [7:0] lstore [256];
  logic [7:0] vm_rd, ls_rd;
  logic [MemAw-1:0] vm_raddr;
  logic [7:0] ls_addr;
  logic ls_we;
  logic [7:0] ls_wdata;

  // sprite latches
  logic signed [9:0] lx [LatchCount];
  logic [7:0] lattr [LatchCount];
  logic [7:0] lpat0 [LatchCount];
  logic [7:0] lpat1 [LatchCount];
  logic [2:0] count;
  logic [7:0] status;
  logic [15:0] coll;

  // evaluation state
  logic [5:0] entry;
  logic signed [9:0] ycur;
  logic [7:0] name;
  logic [4:0] row;
  logic [MemAw-1:0] pat_addr;
  logic [LatchIw-1:0] li;

  // compositing state
  logic [2:0] cs;
  logic [5:0] cx;
  logic [LatchIw-1:0] csi;
  logic signed [10:0] cpos;
  logic cbit;
  logic [5:0] size;
  logic [4:0] col;
  logic [7:0] pbyte;
  logic [5:0] cx_next;
  logic [2:0] cs_next;
  logic cp_last;

  assign size = (size_mode == 2'd0) ? 6'd8 : (size_mode == 2'd3) ? 6'd32 : 6'd16;
  assign csi = cs[LatchIw-1:0];

  // derived scan signals
  logic signed [9:0] yw;
  logic signed [9:0] ldiff;
  logic [4:0] rowc;
  assign yw = (vm_rd > 8'hE0) ? $signed({2'b00, vm_rd}) - 10'sd256
                              : $signed({2'b00, vm_rd});
  assign ldiff = $signed({2'b00, line_q}) - ycur;
  assign rowc = (size_mode[0] ? ldiff[5:1] : ldiff[4:0]) &
                (size_mode[1] ? 5'h0F : 5'h07);

  // current pixel of compositing
  assign col = size_mode[0] ? {1'b0, cx[4:1]} : cx[4:0];
  assign pbyte = col[3] ? lpat1[csi] : lpat0[csi];
  assign cpos = $signed({lx[csi][9], lx[csi]}) + $signed({5'b0, cx});
  assign cbit = pbyte[3'd7 - col[2:0]] && (cpos >= 0) && (cpos <= 11'sd255);
  assign cp_last = (cx + 6'd1 == size);
  assign cx_next = cp_last ? 6'd0 : cx + 6'd1;
  assign cs_next = cp_last ? cs + 3'd1 : cs;

  always_comb begin
    stat.ev_stop = (vm_rd == 8'hD0) ||
                   (($signed({2'b00, line_q}) >= yw) &&
                    ($signed({2'b00, line_q}) < yw + $signed({4'b0, size})) &&
                    (count >= 3'(LatchCount)));
    stat.ev_hit = ($signed({2'b00, line_q}) >= yw) &&
                  ($signed({2'b00, line_q}) < yw + $signed({4'b0, size}));
    stat.ev_last = (entry == 6'(AttrEntries));
    stat.ev_end = (entry + 6'd1 == 6'(AttrEntries));
    stat.cp_done = (cmd.op == OP_CP_INIT) ? (count == 3'd0)
                                          : (cp_last && (cs + 3'd1 >= count));
  end

  // video memory read address
  always_comb begin
    case (cmd.op)
      OP_EV_INIT, OP_EV_PAT1:
        vm_raddr = MemAw'(attribute_base + {6'b0, entry, 2'b00});
      OP_EV_CHECK: vm_raddr = MemAw'(attribute_base + {6'b0, entry, 2'b01});
      OP_EV_X:     vm_raddr = MemAw'(attribute_base + {6'b0, entry, 2'b10});
      OP_EV_NAME:  vm_raddr = MemAw'(attribute_base + {6'b0, entry, 2'b11});
      OP_EV_ATTR:  vm_raddr = MemAw'(pattern_base | {3'b0, name, row[2:0]});
      OP_EV_PAT0:  vm_raddr = MemAw'(pat_addr + 14'h10);
      default:     vm_raddr = MemAw'(attribute_base + {6'b0, entry, 2'b00});
    endcase
  end

  // video memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SIMPLE && act_q == ACT_WR_MEM) vmem[addr_q] <= data_q;
    vm_rd <= vmem[vm_raddr];
  end

  // line store port selection
  always_comb begin
    ls_we = 1'b0;
    ls_wdata = data_q;
    ls_addr = px_q;
    if (cmd.op == OP_SIMPLE) begin
      ls_we = (act_q == ACT_WR_PIX);
    end else if (cmd.op == OP_CP_READ || cmd.op == OP_CP_WRITE) begin
      ls_addr = cpos[7:0];
      ls_we = (cmd.op == OP_CP_WRITE) && cbit && (lattr[csi][3:0] != 4'd0) &&
              !ls_rd[6];
      ls_wdata = {4'h5, lattr[csi][3:0]} | 8'h50;
    end
  end

  always_ff @(posedge clk) begin
    if (ls_we) lstore[ls_addr] <= ls_wdata;
    ls_rd <= lstore[ls_addr];
  end

  // item capture, sequence registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_q <= action;
      addr_q <= mem_address;
      data_q <= data_byte;
      px_q <= pixel_x;
      line_q <= scan_line;
    end
    unique case (cmd.op)
      OP_EV_INIT: entry <= 6'd0;
      OP_EV_CHECK: ycur <= yw;
      OP_EV_X: begin
        lx[li] <= $signed({2'b00, vm_rd});
        row <= rowc;
      end
      OP_EV_NAME: name <= (size_mode[1] ? (vm_rd & 8'hFC) : vm_rd) | {7'b0, row[3]};
      OP_EV_ATTR: begin
        lattr[li] <= vm_rd;
        if (vm_rd[7]) lx[li] <= lx[li] - 10'sd32;
        pat_addr <= MemAw'(pattern_base | {3'b0, name, row[2:0]});
      end
      OP_EV_PAT0: lpat0[li] <= vm_rd;
      OP_EV_PAT1: lpat1[li] <= vm_rd;
      default: ;
    endcase
    if ((cmd.op == OP_EV_CHECK && !stat.ev_stop && !stat.ev_hit) ||
        cmd.op == OP_EV_PAT0)
      entry <= entry + 6'd1;
    if (cmd.op == OP_CP_INIT) begin
      cs <= 3'd0;
      cx <= 6'd0;
    end else if (cmd.op == OP_CP_WRITE) begin
      cs <= cs_next;
      cx <= cx_next;
    end
    if (cmd.op == OP_DONE)
      read_pixel <= (act_q == ACT_RD_PIX) ? ls_rd : 8'd0;
  end

  // the scan stops after visiting every entry without a terminating condition
  logic ev_end;
  assign ev_end = (cmd.op == OP_EV_CHECK) && !stat.ev_stop && !stat.ev_hit &&
                  (entry + 6'd1 == 6'(AttrEntries));

  // control-side registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      status <= 8'd0;
      coll <= 16'd0;
      li <= '0;
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_DONE);
      if (cmd.op == OP_SIMPLE && act_q == ACT_WR_STAT) status <= data_q;
      if (cmd.op == OP_EV_INIT) begin
        count <= 3'd0;
        li <= '0;
      end
      if (cmd.op == OP_EV_CHECK && stat.ev_stop) begin
        if (vm_rd != 8'hD0) status[6] <= 1'b1;
        status[4:0] <= entry[4:0];
      end
      if (ev_end) status[4:0] <= 5'(AttrEntries);
      if (cmd.op == OP_EV_PAT1) begin
        count <= count + 3'd1;
        li <= li + 1'b1;
        if (entry == 6'(AttrEntries)) status[4:0] <= 5'(AttrEntries);
      end
      if (cmd.op == OP_CP_WRITE && cbit && ls_rd[6] && !status[5]) begin
        status[5] <= 1'b1;
        coll <= {line_q, 8'((cpos[8:0] + 9'd13) >> 1)};
      end
    end
  end

  assign status_byte = status;
  assign collision_place = coll;
  assign sprites_latched = count;
endmodule

>>> hdl/sprite_line_engine_top.sv
// Top level of the sprite line engine
// One item at a time: memory, pixel and status actions pass the SIMPLE and
// DONE states; line evaluation passes Y and CHECK for each missed entry and
// also X, NAME, ATTR, PAT0 and PAT1 per latched sprite, through the single
// video memory read port; compositing passes a READ and a WRITE state per
// sprite pixel through the line store. The result shows on the outputs with
// done high for one cycle and cannot be held off; busy is already low in that
// cycle, so the next item can be accepted at the edge that ends it.
module sprite_line_engine_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [2:0] action,
  input  logic [13:0] mem_address,
  input  logic [7:0] data_byte,
  input  logic [7:0] pixel_x,
  input  logic [7:0] scan_line,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [13:0] cfg_data,
  output logic done,
  output logic [7:0] read_pixel,
  output logic [7:0] status_byte,
  output logic [15:0] collision_place,
  output logic [2:0] sprites_latched
);
  import sle_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic [13:0] attribute_base, pattern_base;
  logic [1:0] size_mode;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_base <= '0;
      pattern_base <= '0;
      size_mode <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTR_BASE: attribute_base <= cfg_data;
        REG_PAT_BASE:  pattern_base <= cfg_data;
        REG_SIZE_MODE: size_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  sle_ctrl u_ctrl (.clk, .rst, .start, .action, .stat, .cmd, .busy);

  sle_datapath u_dp (
    .clk, .rst, .start, .busy, .cmd, .stat, .action, .mem_address, .data_byte,
    .pixel_x, .scan_line, .attribute_base, .pattern_base, .size_mode,
    .read_pixel, .status_byte, .collision_place, .sprites_latched, .done
  );
endmodule

>>> hdl/sle_checker.sv
// Port-level checker of the sprite line engine, bound to the top level
`include "sprite_line_engine_top_macros.svh"
module sle_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [2:0] sprites_latched
);
  `SLE_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `SLE_ASSERT_IMP(a_done_busy, clk, rst, done, !busy)
  `SLE_ASSERT_NEXT(a_done_once, clk, rst, done, !done)
  `SLE_ASSERT_IMP(a_count_max, clk, rst, 1'b1, sprites_latched <= 3'd4)
endmodule

bind sprite_line_engine_top sle_checker u_chk (
  .clk, .rst, .start, .busy, .done, .sprites_latched
);
